>>> rtl/slot_linked_list_manager_assert.svh
// Assertion macros for the slot linked list manager.
// Expects clk and rst_n in the scope of each use.
`ifndef SLOT_LINKED_LIST_MANAGER_ASSERT_SVH
`define SLOT_LINKED_LIST_MANAGER_ASSERT_SVH

// Same-cycle implication.
`define SLM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slm assertion failed");

// Next-cycle implication.
`define SLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slm assertion failed");

`endif

>>> rtl/slm_pkg.sv
// Package for the slot linked list manager: mode and status codes,
// controller states and the storage control struct. No dependencies.
`timescale 1ns / 1ps

package slm_pkg;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_WALK   = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_ADD,
        ST_ADD_LINK,
        ST_ADD_SELF,
        ST_REM,
        ST_REM_AFTER,
        ST_REM_FREE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic pay_wr_en;
    } slm_ctl_t;

endpackage

>>> rtl/slm_req_if.sv
// Request channel of the slot linked list manager.
// Depends on nothing; widths follow SLOTS and DATA_WIDTH.
`timescale 1ns / 1ps

interface slm_req_if #(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 32
);
    localparam int SLOT_W = $clog2(SLOTS + 1);

    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [DATA_WIDTH-1:0] payload_in;
    logic [SLOT_W-1:0]     remove_slot;

    modport source (output valid, output mode, output payload_in, output remove_slot,
                    input ready);
    modport sink (input valid, input mode, input payload_in, input remove_slot,
                  output ready);
endinterface

>>> rtl/slm_rsp_if.sv
// Result channel of the slot linked list manager.
// Depends on nothing; widths follow SLOTS and DATA_WIDTH.
`timescale 1ns / 1ps

interface slm_rsp_if #(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 32
);
    localparam int SLOT_W = $clog2(SLOTS + 1);

    logic                  valid;
    logic                  ready;
    logic [SLOT_W-1:0]     slot_out;
    logic [DATA_WIDTH-1:0] payload_out;
    logic [1:0]            status;
    logic                  last;

    modport source (output valid, output slot_out, output payload_out, output status,
                    output last, input ready);
    modport sink (input valid, input slot_out, input payload_out, input status,
                  input last, output ready);
endinterface

>>> rtl/slm_store.sv
// Link table and payload memories with registered reads.
// Depends on slm_pkg for the control struct.
`timescale 1ns / 1ps

module slm_store
    import slm_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int SLOT_W     = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slm_ctl_t              ctl,
    input  logic [SLOT_W-1:0]     rd_addr,
    output logic [SLOT_W-1:0]     link_q,
    output logic [DATA_WIDTH-1:0] pay_q,
    input  logic [SLOT_W-1:0]     wr_addr,
    input  logic [SLOT_W-1:0]     wr_data,
    input  logic [DATA_WIDTH-1:0] pay_wr_data,
    input  logic [SLOT_W-1:0]     scan_addr,
    output logic                  scan_busy
);

    localparam int PIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOT_W-1:0]     link_mem [0:SLOTS];
    logic [DATA_WIDTH-1:0] pay_mem  [0:SLOTS-1];
    logic [SLOTS:0]        nz_reg;
    logic [SLOT_W-1:0]     link_rd_reg;
    logic                  nz_rd_reg;
    logic [DATA_WIDTH-1:0] pay_rd_reg;
    logic [SLOT_W-1:0]     rd_m1;
    logic [SLOT_W-1:0]     wr_m1;

    assign rd_m1 = rd_addr - SLOT_W'(1);
    assign wr_m1 = wr_addr - SLOT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg <= '0;
        end
        else if (ctl.wr_en)
        begin
            nz_reg[wr_addr] <= (wr_data != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            link_rd_reg <= link_mem[rd_addr];
            nz_rd_reg   <= nz_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pay_wr_en)
        begin
            pay_mem[wr_m1[PIDX_W-1:0]] <= pay_wr_data;
        end
        if (ctl.rd_en && (rd_addr != '0))
        begin
            pay_rd_reg <= pay_mem[rd_m1[PIDX_W-1:0]];
        end
    end

    assign link_q    = nz_rd_reg ? link_rd_reg : '0;
    assign pay_q     = pay_rd_reg;
    assign scan_busy = nz_reg[scan_addr];

endmodule

>>> rtl/slot_linked_list_manager.sv
// Slot linked list manager: list kept in a link memory, head at entry 0.
// Add and remove take as long as the walk over the link memory, at one entry
// per cycle through its single read port.
// Walk gives one result per cycle after a first step that reads the head, while results are taken.
// One request at a time. Reset is asynchronous: all slots free, list empty at once.
// Depends on slm_pkg, slm_req_if, slm_rsp_if, slm_store and the assertion header.
`timescale 1ns / 1ps

`include "slot_linked_list_manager_assert.svh"

module slot_linked_list_manager
    import slm_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    slm_req_if.sink   req,
    slm_rsp_if.source rsp
);

    localparam int SLOT_W = $clog2(SLOTS + 1);
    localparam int CNT_W  = $clog2(SLOTS + 2);
    localparam logic [SLOT_W-1:0] SLOT_MAX   = SLOT_W'(SLOTS);
    localparam logic [CNT_W-1:0]  CNT_SLOTS  = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0]  CNT_SLOTS1 = CNT_W'(SLOTS + 1);

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [SLOT_W-1:0]     tgt_reg, tgt_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic [DATA_WIDTH-1:0] pay_reg, pay_next;
    logic                  tail_done_reg, tail_done_next;
    logic                  free_done_reg, free_done_next;
    logic                  free_found_reg, free_found_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic [1:0]            res_status_reg, res_status_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [DATA_WIDTH-1:0] out_pay_reg, out_pay_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic                  out_last_reg, out_last_next;

    slm_ctl_t              ctl;
    logic [SLOT_W-1:0]     rd_addr;
    logic [SLOT_W-1:0]     wr_addr;
    logic [SLOT_W-1:0]     wr_data;
    logic [SLOT_W-1:0]     link_val;
    logic [DATA_WIDTH-1:0] pay_val;
    logic [SLOT_W-1:0]     scan_addr;
    logic                  scan_busy;

    logic                  in_fire;
    logic                  out_free;
    logic                  bad_target;
    logic                  lnk_end;
    logic                  walk_stop;
    logic                  walk_adv;
    logic                  tail_stop;
    logic                  scan_over;
    logic                  rem_miss;
    logic                  rem_hit;
    logic [SLOT_W-1:0]     rem_new;
    logic                  out_load;
    logic [SLOT_W-1:0]     ld_slot;
    logic [DATA_WIDTH-1:0] ld_pay;
    logic [1:0]            ld_status;
    logic                  ld_last;

    slm_store #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH),
        .SLOT_W     (SLOT_W)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .rd_addr     (rd_addr),
        .link_q      (link_val),
        .pay_q       (pay_val),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .pay_wr_data (pay_reg),
        .scan_addr   (scan_addr),
        .scan_busy   (scan_busy)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign in_fire    = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign bad_target = (req.remove_slot == '0) || (req.remove_slot > SLOT_MAX);

    assign lnk_end   = (link_val == cur_reg) || (link_val > SLOT_MAX);
    assign walk_stop = lnk_end || (cnt_reg == CNT_SLOTS);
    assign walk_adv  = (cur_reg == '0) ? !walk_stop : (out_free && !walk_stop);
    assign tail_stop = lnk_end || (cnt_reg == CNT_SLOTS1);
    assign scan_over = (scan_reg > CNT_W'(SLOTS));
    assign scan_addr = scan_over ? '0 : scan_reg[SLOT_W-1:0];
    assign rem_miss  = lnk_end || (cnt_reg == CNT_SLOTS);
    assign rem_hit   = !rem_miss && (link_val == tgt_reg);
    assign rem_new   = ((link_val == tgt_reg) || (link_val > SLOT_MAX)) ? cur_reg : link_val;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (req.mode == MODE_ADD)
                        state_next = ST_ADD;
                    else if (req.mode == MODE_REMOVE)
                        state_next = bad_target ? ST_DONE : ST_REM;
                    else if (req.mode == MODE_WALK)
                        state_next = ST_WALK;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (walk_stop && out_free)
                    state_next = ST_IDLE;
            end
            ST_ADD:
            begin
                if (tail_done_reg && free_done_reg)
                    state_next = free_found_reg ? ST_ADD_LINK : ST_DONE;
            end
            ST_ADD_LINK:  state_next = ST_ADD_SELF;
            ST_ADD_SELF:  state_next = ST_DONE;
            ST_REM:
            begin
                priority if (rem_miss)
                    state_next = ST_DONE;
                else if (rem_hit)
                    state_next = ST_REM_AFTER;
                else
                    state_next = ST_REM;
            end
            ST_REM_AFTER: state_next = ST_REM_FREE;
            ST_REM_FREE:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        rd_addr   = link_val;
        wr_addr   = cur_reg;
        wr_data   = tgt_reg;
        out_load  = 1'b0;
        ld_slot   = res_slot_reg;
        ld_pay    = '0;
        ld_status = res_status_reg;
        ld_last   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.rd_en = in_fire;
                rd_addr   = '0;
            end
            ST_WALK:
            begin
                ctl.rd_en = walk_adv;
                if (cur_reg == '0)
                begin
                    out_load  = walk_stop && out_free;
                    ld_slot   = '0;
                    ld_status = STAT_EMPTY;
                end
                else
                begin
                    out_load  = out_free;
                    ld_slot   = cur_reg;
                    ld_pay    = pay_val;
                    ld_status = STAT_OK;
                    ld_last   = walk_stop;
                end
            end
            ST_ADD:
            begin
                ctl.rd_en = !tail_done_reg && !tail_stop;
            end
            ST_ADD_LINK:
            begin
                ctl.wr_en = 1'b1;
            end
            ST_ADD_SELF:
            begin
                ctl.wr_en     = 1'b1;
                ctl.pay_wr_en = 1'b1;
                wr_addr       = tgt_reg;
            end
            ST_REM:
            begin
                ctl.rd_en = !rem_miss;
                rd_addr   = rem_hit ? tgt_reg : link_val;
            end
            ST_REM_AFTER:
            begin
                ctl.wr_en = 1'b1;
                wr_data   = rem_new;
            end
            ST_REM_FREE:
            begin
                ctl.wr_en = 1'b1;
                wr_addr   = tgt_reg;
                wr_data   = '0;
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_comb
    begin
        cur_next        = cur_reg;
        tgt_next        = tgt_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        pay_next        = pay_reg;
        tail_done_next  = tail_done_reg;
        free_done_next  = free_done_reg;
        free_found_next = free_found_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cur_next        = '0;
                    tgt_next        = req.remove_slot;
                    cnt_next        = '0;
                    scan_next       = CNT_W'(1);
                    pay_next        = req.payload_in;
                    tail_done_next  = 1'b0;
                    free_done_next  = 1'b0;
                    free_found_next = 1'b0;
                    res_slot_next   = '0;
                    res_status_next = STAT_NOT_FOUND;
                end
            end
            ST_WALK:
            begin
                if (walk_adv)
                begin
                    cur_next = link_val;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ADD:
            begin
                if (!tail_done_reg)
                begin
                    if (tail_stop)
                        tail_done_next = 1'b1;
                    else
                    begin
                        cur_next = link_val;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                if (!free_done_reg)
                begin
                    priority if (scan_over)
                        free_done_next = 1'b1;
                    else if (!scan_busy)
                    begin
                        free_done_next  = 1'b1;
                        free_found_next = 1'b1;
                        tgt_next        = scan_reg[SLOT_W-1:0];
                    end
                    else
                        scan_next = scan_reg + CNT_W'(1);
                end
                if (tail_done_reg && free_done_reg && !free_found_reg)
                    res_status_next = STAT_FULL;
            end
            ST_ADD_SELF:
            begin
                res_slot_next   = tgt_reg;
                res_status_next = STAT_OK;
            end
            ST_REM:
            begin
                if (!rem_miss && !rem_hit)
                begin
                    cur_next = link_val;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_REM_FREE:
            begin
                res_slot_next   = tgt_reg;
                res_status_next = STAT_OK;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_slot_next   = out_slot_reg;
        out_pay_next    = out_pay_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_slot_next   = ld_slot;
            out_pay_next    = ld_pay;
            out_status_next = ld_status;
            out_last_next   = ld_last;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        tgt_reg        <= tgt_next;
        cnt_reg        <= cnt_next;
        scan_reg       <= scan_next;
        pay_reg        <= pay_next;
        tail_done_reg  <= tail_done_next;
        free_done_reg  <= free_done_next;
        free_found_reg <= free_found_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        out_slot_reg   <= out_slot_next;
        out_pay_reg    <= out_pay_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.slot_out    = out_slot_reg;
    assign rsp.payload_out = out_pay_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.last        = out_last_reg;

    `SLM_ASSERT_NOW(a_wr_in_table, ctl.wr_en, wr_addr <= SLOT_MAX)
    `SLM_ASSERT_NOW(a_fail_no_slot, rsp.valid && (rsp.status != STAT_OK), rsp.slot_out == '0)
    `SLM_ASSERT_NOW(a_mid_walk_ok, rsp.valid && !rsp.last,
                    (rsp.status == STAT_OK) && (rsp.slot_out != '0))
    `SLM_ASSERT_NEXT(a_add_then_done, state_reg == ST_ADD_SELF,
                     (state_reg == ST_DONE) && (res_status_reg == STAT_OK))

endmodule

>>> bench/slm_list_checker.sv
// Checker for the slot linked list manager: keeps its own copy of the link table
// and payload store, predicts result beats per accepted request and compares them.
// Depends on slm_pkg, slm_req_if and slm_rsp_if.
`timescale 1ns / 1ps

module slm_list_checker
    import slm_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    slm_req_if   req,
    slm_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    localparam int SLOT_W = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        logic [DATA_WIDTH-1:0] data;
        logic [1:0]            status;
        logic                  last;
    } beat_t;

    logic [SLOT_W-1:0]     list_link [0:SLOTS];
    logic [DATA_WIDTH-1:0] slot_data [1:SLOTS];
    beat_t                 expected_beats [$];

    assign pending = expected_beats.size();

    function automatic beat_t make_beat(int slot, logic [DATA_WIDTH-1:0] data,
                                        logic [1:0] status, logic last);
        beat_t b;
        b.slot   = slot[SLOT_W-1:0];
        b.data   = data;
        b.status = status;
        b.last   = last;
        return b;
    endfunction

    task automatic apply_list_op(input logic [1:0] op, input logic [DATA_WIDTH-1:0] word,
                                 input logic [SLOT_W-1:0] target);
        int tail;
        int free_slot;
        int prev;
        int cur;
        int after;
        int count;
        int walk_slots [SLOTS];
        logic found;
        case (op)
            MODE_ADD:
            begin
                tail = 0;
                for (int s = 0; s <= SLOTS; s++)
                begin
                    cur = int'(list_link[tail]);
                    if (cur == tail || cur > SLOTS)
                        break;
                    tail = cur;
                end
                free_slot = 0;
                for (int j = SLOTS; j >= 1; j--)
                    if (list_link[j] == 0)
                        free_slot = j;
                if (free_slot == 0)
                    expected_beats.push_back(make_beat(0, '0, STAT_FULL, 1'b1));
                else
                begin
                    list_link[tail]      = free_slot[SLOT_W-1:0];
                    list_link[free_slot] = free_slot[SLOT_W-1:0];
                    slot_data[free_slot] = word;
                    expected_beats.push_back(make_beat(free_slot, '0, STAT_OK, 1'b1));
                end
            end
            MODE_REMOVE:
            begin
                found = 1'b0;
                if (target != 0 && target <= SLOTS)
                begin
                    prev = 0;
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        cur = int'(list_link[prev]);
                        if (cur == prev || cur > SLOTS)
                            break;
                        if (cur == target)
                        begin
                            after = int'(list_link[cur]);
                            if (after == cur || after > SLOTS)
                                list_link[prev] = prev[SLOT_W-1:0];
                            else
                                list_link[prev] = after[SLOT_W-1:0];
                            list_link[cur] = '0;
                            found = 1'b1;
                            break;
                        end
                        prev = cur;
                    end
                end
                if (found)
                    expected_beats.push_back(make_beat(int'(target), '0, STAT_OK, 1'b1));
                else
                    expected_beats.push_back(make_beat(0, '0, STAT_NOT_FOUND, 1'b1));
            end
            MODE_WALK:
            begin
                prev = 0;
                count = 0;
                while (count < SLOTS)
                begin
                    cur = int'(list_link[prev]);
                    if (cur == prev || cur > SLOTS)
                        break;
                    walk_slots[count] = cur;
                    prev = cur;
                    count++;
                end
                if (count == 0)
                    expected_beats.push_back(make_beat(0, '0, STAT_EMPTY, 1'b1));
                for (int k = 0; k < count; k++)
                    expected_beats.push_back(make_beat(walk_slots[k], slot_data[walk_slots[k]],
                                                       STAT_OK, k == count - 1));
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_beat();
        beat_t want;
        if (expected_beats.size() == 0)
        begin
            $error("unexpected beat: slot_out %0d payload_out %h status %0d last %0d",
                   rsp.slot_out, rsp.payload_out, rsp.status, rsp.last);
            fail_count++;
            return;
        end
        want = expected_beats.pop_front();
        if (rsp.slot_out !== want.slot)
        begin
            $error("slot_out expected %0d actual %0d", want.slot, rsp.slot_out);
            fail_count++;
        end
        if (rsp.payload_out !== want.data)
        begin
            $error("payload_out expected %h actual %h", want.data, rsp.payload_out);
            fail_count++;
        end
        if (rsp.status !== want.status)
        begin
            $error("status expected %0d actual %0d", want.status, rsp.status);
            fail_count++;
        end
        if (rsp.last !== want.last)
        begin
            $error("last expected %0d actual %0d", want.last, rsp.last);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            for (int i = 0; i <= SLOTS; i++)
                list_link[i] = '0;
            for (int i = 1; i <= SLOTS; i++)
                slot_data[i] = '0;
            expected_beats.delete();
        end
        else
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
                apply_list_op(req.mode, req.payload_in, req.remove_slot);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                compare_beat();
        end
    end

endmodule

>>> bench/tb.sv
// Top of the slot linked list manager bench: clock, reset, request stimulus and
// result back-pressure in several idle phases; verdict from the list checker.
// Depends on slm_pkg, slm_req_if, slm_rsp_if, slm_list_checker and the block.
`timescale 1ns / 1ps

module tb
    import slm_pkg::*;
();

    localparam int SLOTS        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int SLOT_W       = $clog2(SLOTS + 1);
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 80;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    slm_req_if #(.SLOTS(SLOTS), .DATA_WIDTH(DATA_WIDTH)) req ();
    slm_rsp_if #(.SLOTS(SLOTS), .DATA_WIDTH(DATA_WIDTH)) rsp ();

    int fail_count;
    int pending_beats;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;

    slot_linked_list_manager #(.SLOTS(SLOTS), .DATA_WIDTH(DATA_WIDTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    slm_list_checker #(.SLOTS(SLOTS), .DATA_WIDTH(DATA_WIDTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending_beats)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hold off results for a long stretch once, otherwise stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            rsp.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_taken)
        begin
            rsp.ready  <= 1'b0;
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input logic [1:0] op, input logic [DATA_WIDTH-1:0] word,
                             input logic [SLOT_W-1:0] target);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= op;
        req.payload_in  <= word;
        req.remove_slot <= target;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic random_phase(input int add_pct, input int idle_pct, input int stall_pct);
        int done;
        int pick;
        logic [1:0] op;
        logic [SLOT_W-1:0] target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                op = MODE_UNUSED;
            else if (pick < 2 + add_pct)
                op = MODE_ADD;
            else if (pick < 87)
                op = MODE_REMOVE;
            else
                op = MODE_WALK;
            target = SLOT_W'($urandom_range(1, SLOTS));
            if ($urandom_range(9) == 0)
                target = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
            send_item(op, $urandom, target);
            if (op != MODE_UNUSED)
                done++;
        end
    endtask

    initial
    begin
        req.valid       = 1'b0;
        req.mode        = MODE_ADD;
        req.payload_in  = '0;
        req.remove_slot = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_WALK, '0, '0);
        send_item(MODE_REMOVE, '0, SLOT_W'(3));
        send_item(MODE_REMOVE, '0, '0);
        send_item(MODE_REMOVE, '0, '1);
        send_item(MODE_UNUSED, 32'hA5A5_5A5A, SLOT_W'(SLOTS));
        send_item(MODE_ADD, 32'hFFFF_FFFF, '0);
        send_item(MODE_REMOVE, '0, SLOT_W'(1));
        for (int k = 0; k < SLOTS; k++)
            send_item(MODE_ADD, ~(32'h1 << k), SLOT_W'(k));
        send_item(MODE_ADD, '0, '0);
        send_item(MODE_WALK, '0, '0);
        send_item(MODE_REMOVE, '0, SLOT_W'(SLOTS));
        send_item(MODE_REMOVE, '0, SLOT_W'(1));
        send_item(MODE_REMOVE, '0, SLOT_W'(5));
        send_item(MODE_ADD, $urandom, '0);
        send_item(MODE_WALK, '0, '0);

        random_phase(55, 0, 0);
        hold_request = 1'b1;
        random_phase(45, 0, 0);
        random_phase(60, 82, 0);
        random_phase(30, 0, 82);
        random_phase(45, 20, 20);

        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (3 * SLOTS) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
